// ===== design/oae_pkg.sv =====
// ----------------------------------------------------------------------------
// oae_pkg: shared types, codes and permutation functions
// Word and block types, command codes and the round logic of the
// 1024-bit permutation, plus mask and padding helpers.
// ----------------------------------------------------------------------------
package oae_pkg;

    localparam int ROUNDS    = 4;
    localparam int TAG_BITS  = 256;
    localparam int TAG_WORDS = TAG_BITS / 64;
    localparam int ROUND_W   = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    typedef logic [63:0] word_t;
    typedef word_t [15:0] blk_t;

    // configuration register indexes
    localparam logic [2:0] CFG_KEY0   = 3'd0;
    localparam logic [2:0] CFG_KEY1   = 3'd1;
    localparam logic [2:0] CFG_KEY2   = 3'd2;
    localparam logic [2:0] CFG_KEY3   = 3'd3;
    localparam logic [2:0] CFG_NONCE0 = 3'd4;
    localparam logic [2:0] CFG_NONCE1 = 3'd5;
    localparam logic [2:0] CFG_DIR    = 3'd6;

    // input commands
    localparam logic [2:0] CMD_START  = 3'd0;
    localparam logic [2:0] CMD_HEADER = 3'd1;
    localparam logic [2:0] CMD_PAY    = 3'd2;
    localparam logic [2:0] CMD_FINISH = 3'd3;
    localparam logic [2:0] CMD_TAG    = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_PAY     = 2'd0;
    localparam logic [1:0] KIND_TAG     = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_INIT_H,
        OP_SAVE_H,
        OP_SAVE_P,
        OP_STEP,
        OP_WRITE_BUF,
        OP_HLOAD_FULL,
        OP_HLOAD_LAST,
        OP_HCOMMIT,
        OP_PLOAD_FULL,
        OP_PLOAD_LAST,
        OP_PCOMMIT_FULL,
        OP_PCOMMIT_LAST,
        OP_FLOAD,
        OP_FCOMMIT,
        OP_TAG_CMP
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       step_inv;
        logic       step_diag;
        logic [1:0] step_sub;
        logic       use_n;
        logic       fill_inc;
        logic       fill_clr;
        logic       latch;
        logic       emit;
        logic [3:0] emit_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] fill;
        logic [3:0] nbytes;
        logic       ends;
        logic       dir;
        logic       out_free;
        logic       tag_last;
        logic [4:0] cnt;
    } dp_stat_t;

    function automatic word_t ror64(word_t x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic word_t rol64(word_t x, int n);
        return (x << n) | (x >> (64 - n));
    endfunction

    function automatic word_t byte_mask(logic [3:0] n);
        word_t m;
        if (n[3]) begin
            m = '1;
        end else begin
            m = (64'd1 << {n[2:0], 3'b000}) - 64'd1;
        end
        return m;
    endfunction

    // one add/xor/rotate sub-step of a G function, forward or inverse
    function automatic blk_t gsub(blk_t s, int a, int b, int c, int d,
                                  logic inv, logic [1:0] sub);
        blk_t r;
        r = s;
        if (!inv) begin
            case (sub)
                2'd0: begin r[a] = r[a] + r[b]; r[d] = ror64(r[d] ^ r[a], 32); end
                2'd1: begin r[c] = r[c] + r[d]; r[b] = ror64(r[b] ^ r[c], 24); end
                2'd2: begin r[a] = r[a] + r[b]; r[d] = ror64(r[d] ^ r[a], 16); end
                default: begin r[c] = r[c] + r[d]; r[b] = ror64(r[b] ^ r[c], 63); end
            endcase
        end else begin
            case (sub)
                2'd0: begin r[b] = rol64(r[b], 63) ^ r[c]; r[c] = r[c] - r[d]; end
                2'd1: begin r[d] = rol64(r[d], 16) ^ r[a]; r[a] = r[a] - r[b]; end
                2'd2: begin r[b] = rol64(r[b], 24) ^ r[c]; r[c] = r[c] - r[d]; end
                default: begin r[d] = rol64(r[d], 32) ^ r[a]; r[a] = r[a] - r[b]; end
            endcase
        end
        return r;
    endfunction

    // four independent G lanes, on columns or diagonals
    function automatic blk_t perm_step(blk_t s, logic inv, logic diag, logic [1:0] sub);
        blk_t r;
        r = s;
        for (int g = 0; g < 4; g++) begin
            if (!diag) begin
                r = gsub(r, g, 4 + g, 8 + g, 12 + g, inv, sub);
            end else begin
                r = gsub(r, g, 4 + ((g + 1) % 4), 8 + ((g + 2) % 4),
                         12 + ((g + 3) % 4), inv, sub);
            end
        end
        return r;
    endfunction

    function automatic blk_t mask_update(blk_t k);
        blk_t r;
        for (int j = 0; j < 15; j++) begin
            r[j] = k[j + 1];
        end
        r[15] = ror64(k[0], 9) ^ (k[9] >> 7);
        return r;
    endfunction

    function automatic blk_t mask_rot(blk_t k, int by);
        blk_t r;
        for (int j = 0; j < 16; j++) begin
            r[j] = k[(j + by) % 16];
        end
        return r;
    endfunction

    function automatic blk_t pad_blk(blk_t src, logic [7:0] len);
        blk_t       d;
        logic [4:0] words;
        words = 5'((9'(len) + 9'd7) >> 3);
        for (int j = 0; j < 16; j++) begin
            d[j] = (5'(j) < words) ? src[j] : '0;
        end
        d[len[6:3]] = d[len[6:3]] | (64'h1 << {len[2:0], 3'b000});
        d[15] = d[15] | (64'h80 << 56);
        return d;
    endfunction

    function automatic blk_t init_blk(word_t nl, word_t nh, word_t k0, word_t k1,
                                      word_t k2, word_t k3, logic tagnum);
        blk_t r;
        r     = '0;
        r[0]  = nl;
        r[1]  = nh;
        r[4]  = k0;
        r[5]  = k1;
        r[6]  = k2;
        r[7]  = k3;
        r[12] = 64'd64;
        r[13] = 64'(ROUNDS);
        r[14] = 64'(TAG_BITS);
        r[15] = {63'd0, tagnum};
        return r;
    endfunction

endpackage

// ===== design/oae_datapath.sv =====
// ----------------------------------------------------------------------------
// oae_datapath: block state, permutation round unit and result register
// Holds masks, sums, block buffer and working state; executes one
// command from the controller per cycle.
// ----------------------------------------------------------------------------
module oae_datapath import oae_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata,
    input  logic [71:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [71:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  dp_cmd_t     cmd_i,
    output dp_stat_t    stat_o
);

    word_t      key0_reg, key1_reg, key2_reg, key3_reg, nonce0_reg, nonce1_reg;
    logic       dir_reg;
    logic [2:0] in_cmd_reg;
    word_t      in_data_reg;
    logic [3:0] in_n_reg;
    logic       in_ends_reg;

    blk_t hmask_reg, hmask_next, pmask_reg, pmask_next;
    blk_t hsum_reg, hsum_next, psum_reg, psum_next;
    blk_t blkbuf_reg, blkbuf_next, perm_reg, perm_next, obuf_reg, obuf_next;

    logic [3:0] fill_reg, fill_next;
    logic [1:0] tidx_reg, tidx_next;
    logic       match_reg, match_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [3:0] lastb_reg, lastb_next;
    logic [1:0] kind_reg, kind_next;

    word_t      out_data_reg, out_data_next;
    logic [3:0] out_bytes_reg, out_bytes_next;
    logic       out_auth_reg, out_auth_next;
    logic [1:0] out_kind_reg, out_kind_next;
    logic       out_last_reg, out_last_next;
    logic       out_valid_reg, out_valid_next;

    logic [7:0] len_n, len_c;
    logic [4:0] words_n;
    logic [3:0] lastb_n, raw_n, norm_n;
    logic       out_free, emit_last;
    word_t      masked_word;

    assign len_n   = {1'b0, fill_reg, 3'b000} + {4'b0000, in_n_reg};
    assign len_c   = {1'b0, fill_reg, 3'b000};
    assign words_n = 5'((9'(len_n) + 9'd7) >> 3);
    assign lastb_n = (len_n[2:0] == 3'd0) ? 4'd8 : {1'b0, len_n[2:0]};
    assign masked_word = in_data_reg & byte_mask(in_n_reg);

    assign raw_n  = s_tdata[67:64];
    assign norm_n = (raw_n == 4'd0 || raw_n > 4'd8) ? 4'd8 : raw_n;

    assign out_free  = !out_valid_reg || m_tready;
    assign emit_last = ({1'b0, cmd_i.emit_idx} == cnt_reg - 5'd1);

    always_comb begin
        blk_t r;
        blk_t o;
        hmask_next  = hmask_reg;
        pmask_next  = pmask_reg;
        hsum_next   = hsum_reg;
        psum_next   = psum_reg;
        blkbuf_next = blkbuf_reg;
        perm_next   = perm_reg;
        obuf_next   = obuf_reg;
        fill_next   = fill_reg;
        tidx_next   = tidx_reg;
        match_next  = match_reg;
        cnt_next    = cnt_reg;
        lastb_next  = lastb_reg;
        kind_next   = kind_reg;
        r = '0;
        o = '0;
        case (cmd_i.op)
            OP_LOAD_INIT_H: begin
                perm_next = init_blk(nonce0_reg, nonce1_reg, key0_reg, key1_reg,
                                     key2_reg, key3_reg, 1'b0);
            end
            OP_SAVE_H: begin
                hmask_next = perm_reg;
                perm_next  = init_blk(nonce0_reg, nonce1_reg, key0_reg, key1_reg,
                                      key2_reg, key3_reg, 1'b1);
            end
            OP_SAVE_P: begin
                pmask_next = perm_reg;
                hsum_next  = '0;
                psum_next  = '0;
                tidx_next  = 2'd0;
                match_next = 1'b1;
            end
            OP_STEP: begin
                perm_next = perm_step(perm_reg, cmd_i.step_inv, cmd_i.step_diag,
                                      cmd_i.step_sub);
            end
            OP_WRITE_BUF: begin
                blkbuf_next[fill_reg] = masked_word;
            end
            OP_HLOAD_FULL: begin
                perm_next = hmask_reg ^ blkbuf_reg;
            end
            OP_HLOAD_LAST: begin
                r          = mask_rot(hmask_reg, 4);
                hmask_next = r;
                perm_next  = r ^ pad_blk(blkbuf_reg, cmd_i.use_n ? len_n : len_c);
            end
            OP_HCOMMIT: begin
                hsum_next  = hsum_reg ^ hmask_reg ^ perm_reg;
                hmask_next = mask_update(hmask_reg);
            end
            OP_PLOAD_FULL: begin
                perm_next = pmask_reg ^ blkbuf_reg;
            end
            OP_PLOAD_LAST: begin
                r          = mask_rot(pmask_reg, 12);
                pmask_next = r;
                perm_next  = r;
            end
            OP_PCOMMIT_FULL: begin
                o          = pmask_reg ^ perm_reg;
                obuf_next  = o;
                psum_next  = psum_reg ^ (dir_reg ? o : blkbuf_reg);
                pmask_next = mask_update(pmask_reg);
                cnt_next   = 5'd16;
                lastb_next = 4'd8;
                kind_next  = KIND_PAY;
            end
            OP_PCOMMIT_LAST: begin
                r = perm_reg ^ pmask_reg ^ blkbuf_reg;
                for (int j = 0; j < 16; j++) begin
                    if (5'(j) < words_n) begin
                        o[j] = (5'(j) == words_n - 5'd1) ? (r[j] & byte_mask(lastb_n))
                                                         : r[j];
                    end
                end
                obuf_next  = o;
                psum_next  = psum_reg ^ pad_blk(dir_reg ? o : blkbuf_reg, len_n);
                cnt_next   = words_n;
                lastb_next = lastb_n;
                kind_next  = KIND_PAY;
            end
            OP_FLOAD: begin
                r          = mask_rot(hmask_reg, 8);
                hmask_next = r;
                psum_next  = psum_reg ^ r;
                perm_next  = psum_reg ^ r;
            end
            OP_FCOMMIT: begin
                r         = hsum_reg ^ perm_reg ^ hmask_reg;
                hsum_next = r;
                psum_next = perm_reg;
                for (int j = 0; j < TAG_WORDS; j++) begin
                    obuf_next[j] = r[j];
                end
                cnt_next   = 5'(TAG_WORDS);
                lastb_next = 4'd8;
                kind_next  = KIND_TAG;
                tidx_next  = 2'd0;
                match_next = 1'b1;
            end
            OP_TAG_CMP: begin
                if (in_data_reg != hsum_reg[tidx_reg]) begin
                    match_next = 1'b0;
                end
                if (tidx_reg == 2'(TAG_WORDS - 1)) begin
                    tidx_next  = 2'd0;
                    cnt_next   = 5'd1;
                    lastb_next = 4'd8;
                    kind_next  = KIND_VERDICT;
                end else begin
                    tidx_next = tidx_reg + 2'd1;
                end
            end
            default: begin
            end
        endcase
        if (cmd_i.fill_clr) begin
            fill_next = 4'd0;
        end else if (cmd_i.fill_inc) begin
            fill_next = fill_reg + 4'd1;
        end
    end

    // result register: loaded from the output block or the verdict, one word a cycle while it is free
    always_comb begin
        out_data_next  = out_data_reg;
        out_bytes_next = out_bytes_reg;
        out_auth_next  = out_auth_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        if (cmd_i.emit && out_free) begin
            out_valid_next = 1'b1;
            out_kind_next  = kind_reg;
            out_last_next  = emit_last;
            if (kind_reg == KIND_VERDICT) begin
                out_data_next  = '0;
                out_bytes_next = 4'd8;
                out_auth_next  = match_reg;
            end else begin
                out_data_next  = obuf_reg[cmd_i.emit_idx];
                out_bytes_next = emit_last ? lastb_reg : 4'd8;
                out_auth_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg      <= '0;
            key1_reg      <= '0;
            key2_reg      <= '0;
            key3_reg      <= '0;
            nonce0_reg    <= '0;
            nonce1_reg    <= '0;
            dir_reg       <= 1'b0;
            fill_reg      <= 4'd0;
            tidx_reg      <= 2'd0;
            match_reg     <= 1'b1;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_KEY0:   key0_reg   <= cfg_wdata;
                    CFG_KEY1:   key1_reg   <= cfg_wdata;
                    CFG_KEY2:   key2_reg   <= cfg_wdata;
                    CFG_KEY3:   key3_reg   <= cfg_wdata;
                    CFG_NONCE0: nonce0_reg <= cfg_wdata;
                    CFG_NONCE1: nonce1_reg <= cfg_wdata;
                    CFG_DIR:    dir_reg    <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            fill_reg      <= fill_next;
            tidx_reg      <= tidx_next;
            match_reg     <= match_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.latch) begin
            in_cmd_reg  <= s_tuser;
            in_data_reg <= s_tdata[63:0];
            in_n_reg    <= norm_n;
            in_ends_reg <= s_tlast || (norm_n < 4'd8);
        end
        hmask_reg     <= hmask_next;
        pmask_reg     <= pmask_next;
        hsum_reg      <= hsum_next;
        psum_reg      <= psum_next;
        blkbuf_reg    <= blkbuf_next;
        perm_reg      <= perm_next;
        obuf_reg      <= obuf_next;
        lastb_reg     <= lastb_next;
        kind_reg      <= kind_next;
        out_data_reg  <= out_data_next;
        out_bytes_reg <= out_bytes_next;
        out_auth_reg  <= out_auth_next;
        out_kind_reg  <= out_kind_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_auth_reg, out_bytes_reg, out_data_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    assign stat_o.cmd      = in_cmd_reg;
    assign stat_o.fill     = fill_reg;
    assign stat_o.nbytes   = in_n_reg;
    assign stat_o.ends     = in_ends_reg;
    assign stat_o.dir      = dir_reg;
    assign stat_o.out_free = out_free;
    assign stat_o.tag_last = (tidx_reg == 2'(TAG_WORDS - 1));
    assign stat_o.cnt      = cnt_reg;

endmodule

// ===== design/oae_ctrl.sv =====
// ----------------------------------------------------------------------------
// oae_ctrl: sequencer for the engine
// Decodes each word, tracks the session phase, runs the round counter
// of the permutation and paces the result words.
// ----------------------------------------------------------------------------
module oae_ctrl import oae_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat_i,
    output dp_cmd_t  cmd_o
);

    typedef enum logic [15:0] {
        ST_IDLE         = 16'h0001,
        ST_DECODE       = 16'h0002,
        ST_PERM         = 16'h0004,
        ST_START_H      = 16'h0008,
        ST_START_P      = 16'h0010,
        ST_HLOAD_FULL   = 16'h0020,
        ST_HLOAD_LAST   = 16'h0040,
        ST_HCOMMIT      = 16'h0080,
        ST_PWRITE       = 16'h0100,
        ST_PLOAD_FULL   = 16'h0200,
        ST_PLOAD_LAST   = 16'h0400,
        ST_PCOMMIT_FULL = 16'h0800,
        ST_PCOMMIT_LAST = 16'h1000,
        ST_FLOAD        = 16'h2000,
        ST_FCOMMIT      = 16'h4000,
        ST_EMIT         = 16'h8000
    } state_t;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_HEAD   = 5'b00010,
        PH_PAY    = 5'b00100,
        PH_CLOSED = 5'b01000,
        PH_VERIFY = 5'b10000
    } phase_t;

    state_t state_reg, state_next, ret_reg, ret_next, cont_reg, cont_next;
    phase_t phase_reg, phase_next;
    logic [ROUND_W-1:0] rnd_reg, rnd_next;
    logic       half_reg, half_next, sub_last;
    logic [1:0] sub_reg, sub_next;
    logic       inv_reg, inv_next, close_reg, close_next;
    logic [3:0] idx_reg, idx_next;
    logic       full;

    assign full     = (stat_i.fill == 4'd15) && (stat_i.nbytes == 4'd8);
    assign sub_last = (sub_reg == 2'd3);
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cont_next  = cont_reg;
        phase_next = phase_reg;
        rnd_next   = rnd_reg;
        half_next  = half_reg;
        sub_next   = sub_reg;
        inv_next   = inv_reg;
        close_next = close_reg;
        idx_next   = idx_reg;
        cmd_o      = '0;
        cmd_o.op   = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                cmd_o.latch = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_IDLE;
                case (stat_i.cmd)
                    CMD_START: begin
                        cmd_o.op   = OP_LOAD_INIT_H;
                        inv_next   = 1'b0;
                        ret_next   = ST_START_H;
                        state_next = ST_PERM;
                    end
                    CMD_HEADER: begin
                        if (phase_reg == PH_HEAD) begin
                            cmd_o.op = OP_WRITE_BUF;
                            if (stat_i.ends) begin
                                phase_next = PH_PAY;
                            end
                            cont_next = ST_IDLE;
                            if (full) begin
                                state_next = ST_HLOAD_FULL;
                            end else if (stat_i.ends) begin
                                close_next = 1'b0;
                                state_next = ST_HLOAD_LAST;
                            end else begin
                                cmd_o.fill_inc = 1'b1;
                            end
                        end
                    end
                    CMD_PAY: begin
                        if (phase_reg == PH_HEAD) begin
                            phase_next = PH_PAY;
                            if (stat_i.fill != 4'd0) begin
                                close_next = 1'b1;
                                cont_next  = ST_PWRITE;
                                state_next = ST_HLOAD_LAST;
                            end else begin
                                state_next = ST_PWRITE;
                            end
                        end else if (phase_reg == PH_PAY) begin
                            state_next = ST_PWRITE;
                        end
                    end
                    CMD_FINISH: begin
                        if (phase_reg == PH_HEAD && stat_i.fill != 4'd0) begin
                            close_next = 1'b1;
                            cont_next  = ST_FLOAD;
                            state_next = ST_HLOAD_LAST;
                        end else if (phase_reg == PH_HEAD || phase_reg == PH_CLOSED ||
                                     (phase_reg == PH_PAY && stat_i.fill == 4'd0)) begin
                            cmd_o.fill_clr = 1'b1;
                            state_next     = ST_FLOAD;
                        end
                    end
                    CMD_TAG: begin
                        if (phase_reg == PH_VERIFY) begin
                            cmd_o.op = OP_TAG_CMP;
                            if (stat_i.tag_last) begin
                                phase_next = PH_IDLE;
                                idx_next   = 4'd0;
                                state_next = ST_EMIT;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_PERM: begin
                cmd_o.op        = OP_STEP;
                cmd_o.step_inv  = inv_reg;
                cmd_o.step_diag = inv_reg ? ~half_reg : half_reg;
                cmd_o.step_sub  = sub_reg;
                sub_next        = sub_reg + 2'd1;
                if (sub_last) begin
                    half_next = ~half_reg;
                    if (half_reg) begin
                        if (rnd_reg == ROUND_W'(ROUNDS - 1)) begin
                            rnd_next   = '0;
                            state_next = ret_reg;
                        end else begin
                            rnd_next = rnd_reg + 1'b1;
                        end
                    end
                end
            end
            ST_START_H: begin
                cmd_o.op   = OP_SAVE_H;
                inv_next   = 1'b0;
                ret_next   = ST_START_P;
                state_next = ST_PERM;
            end
            ST_START_P: begin
                cmd_o.op       = OP_SAVE_P;
                cmd_o.fill_clr = 1'b1;
                phase_next     = PH_HEAD;
                state_next     = ST_IDLE;
            end
            ST_HLOAD_FULL: begin
                cmd_o.op   = OP_HLOAD_FULL;
                inv_next   = 1'b0;
                ret_next   = ST_HCOMMIT;
                state_next = ST_PERM;
            end
            ST_HLOAD_LAST: begin
                cmd_o.op    = OP_HLOAD_LAST;
                cmd_o.use_n = ~close_reg;
                inv_next    = 1'b0;
                ret_next    = ST_HCOMMIT;
                state_next  = ST_PERM;
            end
            ST_HCOMMIT: begin
                cmd_o.op       = OP_HCOMMIT;
                cmd_o.fill_clr = 1'b1;
                state_next     = cont_reg;
            end
            ST_PWRITE: begin
                cmd_o.op   = OP_WRITE_BUF;
                state_next = ST_IDLE;
                if (stat_i.ends) begin
                    phase_next = PH_CLOSED;
                end
                if (full) begin
                    state_next = ST_PLOAD_FULL;
                end else if (stat_i.ends) begin
                    state_next = ST_PLOAD_LAST;
                end else begin
                    cmd_o.fill_inc = 1'b1;
                end
            end
            ST_PLOAD_FULL: begin
                cmd_o.op   = OP_PLOAD_FULL;
                inv_next   = stat_i.dir;
                ret_next   = ST_PCOMMIT_FULL;
                state_next = ST_PERM;
            end
            ST_PLOAD_LAST: begin
                cmd_o.op   = OP_PLOAD_LAST;
                inv_next   = 1'b0;
                ret_next   = ST_PCOMMIT_LAST;
                state_next = ST_PERM;
            end
            ST_PCOMMIT_FULL: begin
                cmd_o.op       = OP_PCOMMIT_FULL;
                cmd_o.fill_clr = 1'b1;
                idx_next       = 4'd0;
                state_next     = ST_EMIT;
            end
            ST_PCOMMIT_LAST: begin
                cmd_o.op       = OP_PCOMMIT_LAST;
                cmd_o.use_n    = 1'b1;
                cmd_o.fill_clr = 1'b1;
                idx_next       = 4'd0;
                state_next     = ST_EMIT;
            end
            ST_FLOAD: begin
                cmd_o.op   = OP_FLOAD;
                inv_next   = 1'b0;
                ret_next   = ST_FCOMMIT;
                state_next = ST_PERM;
            end
            ST_FCOMMIT: begin
                cmd_o.op = OP_FCOMMIT;
                idx_next = 4'd0;
                if (!stat_i.dir) begin
                    phase_next = PH_IDLE;
                    state_next = ST_EMIT;
                end else begin
                    phase_next = PH_VERIFY;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                cmd_o.emit     = 1'b1;
                cmd_o.emit_idx = idx_reg;
                if (stat_i.out_free) begin
                    idx_next = idx_reg + 4'd1;
                    if ({1'b0, idx_reg} == stat_i.cnt - 5'd1) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            cont_reg  <= ST_IDLE;
            phase_reg <= PH_IDLE;
            rnd_reg   <= '0;
            half_reg  <= 1'b0;
            sub_reg   <= 2'd0;
            inv_reg   <= 1'b0;
            close_reg <= 1'b0;
            idx_reg   <= 4'd0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cont_reg  <= cont_next;
            phase_reg <= phase_next;
            rnd_reg   <= rnd_next;
            half_reg  <= half_next;
            sub_reg   <= sub_next;
            inv_reg   <= inv_next;
            close_reg <= close_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== design/opp_aead_engine.sv =====
// ----------------------------------------------------------------------------
// opp_aead_engine: offset public permutation AEAD engine, top level
//
//  channel  dir  handshake          contents
//  s_       in   s_tvalid/s_tready  tdata: data[63:0] bytes[67:64]; tuser: cmd; tlast
//  m_       out  m_tvalid/m_tready  tdata: data, bytes, auth_ok; tuser: kind; tlast
//  cfg_     in   cfg_wr_en          cfg_addr register index, cfg_wdata value
//
// A header word that does not complete a block passes through the idle and
// decode states, a payload word also through the write state. A block that
// runs the permutation adds the rounds of the round unit (one G sub-step on
// four lanes per cycle), a load, a commit and the emission of its result
// words. Start runs the permutation twice. Reset (aresetn low, sync) clears
// phase, counters and the result valid flag. A stalled m_ side holds emission;
// the next input word is taken while the last result waits.
// ----------------------------------------------------------------------------
module opp_aead_engine import oae_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // in_data[63:0], in_bytes[67:64], zero fill
    input  logic [2:0]  s_tuser,   // cmd[2:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // out_data[63:0], out_bytes[67:64], auth_ok[68]
    output logic [1:0]  m_tuser,   // out_kind[1:0]
    output logic        m_tlast
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    oae_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat_i   (dp_stat),
        .cmd_o    (dp_cmd)
    );

    oae_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd_i     (dp_cmd),
        .stat_o    (dp_stat)
    );

endmodule

// ===== test/tb_opp_aead_engine.sv =====
// ----------------------------------------------------------------------------
// tb_opp_aead_engine: self-checking testbench for the OPP AEAD engine
// Streams sessions of start, header, payload, finish and tag words under
// several key, nonce and direction settings. A local model of the engine
// predicts every payload, tag and verdict word, and a monitor compares them
// in order while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_opp_aead_engine;
    import oae_pkg::*;

    typedef struct {
        logic [2:0]  cmd;
        logic [63:0] data;
        logic [3:0]  nb;
        logic        last;
    } in_word_t;

    typedef struct {
        logic [1:0]  kind;
        logic [63:0] data;
        logic [3:0]  nb;
        logic        last;
        logic        ok;
    } out_word_t;

    typedef enum int {ST_IDLE, ST_HEAD, ST_PAY, ST_CLOSED, ST_VERIFY} sess_t;

    localparam int SETTLE = 600;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [63:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    opp_aead_engine u_dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // engine shadow state
    word_t     key_w [4];
    word_t     nonce_w [2];
    logic      dir_dec;
    blk_t      hdr_mask, pay_mask, hdr_sum, pay_sum, blk_buf;
    int        fill;
    sess_t     sess;
    int        tag_pos;
    logic      tag_good;

    in_word_t  pending_q [$];
    out_word_t expected_q [$];
    in_word_t  cur_word;
    int        errors = 0;

    function automatic word_t rotr(word_t x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic word_t rotl(word_t x, int n);
        return (x << n) | (x >> (64 - n));
    endfunction

    function automatic word_t low_bytes(int n);
        return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function automatic blk_t mix(blk_t s, int a, int b, int c, int d);
        s[a] = s[a] + s[b]; s[d] = rotr(s[d] ^ s[a], 32);
        s[c] = s[c] + s[d]; s[b] = rotr(s[b] ^ s[c], 24);
        s[a] = s[a] + s[b]; s[d] = rotr(s[d] ^ s[a], 16);
        s[c] = s[c] + s[d]; s[b] = rotr(s[b] ^ s[c], 63);
        return s;
    endfunction

    function automatic blk_t unmix(blk_t s, int a, int b, int c, int d);
        s[b] = rotl(s[b], 63) ^ s[c]; s[c] = s[c] - s[d];
        s[d] = rotl(s[d], 16) ^ s[a]; s[a] = s[a] - s[b];
        s[b] = rotl(s[b], 24) ^ s[c]; s[c] = s[c] - s[d];
        s[d] = rotl(s[d], 32) ^ s[a]; s[a] = s[a] - s[b];
        return s;
    endfunction

    function automatic blk_t scramble(blk_t s);
        for (int r = 0; r < ROUNDS; r++) begin
            for (int g = 0; g < 4; g++) s = mix(s, g, 4 + g, 8 + g, 12 + g);
            for (int g = 0; g < 4; g++) begin
                s = mix(s, g, 4 + (g + 1) % 4, 8 + (g + 2) % 4, 12 + (g + 3) % 4);
            end
        end
        return s;
    endfunction

    function automatic blk_t unscramble(blk_t s);
        for (int r = 0; r < ROUNDS; r++) begin
            for (int g = 0; g < 4; g++) begin
                s = unmix(s, g, 4 + (g + 1) % 4, 8 + (g + 2) % 4, 12 + (g + 3) % 4);
            end
            for (int g = 0; g < 4; g++) s = unmix(s, g, 4 + g, 8 + g, 12 + g);
        end
        return s;
    endfunction

    function automatic blk_t seed_mask(logic [63:0] tagnum);
        blk_t k;
        k = '0;
        k[0] = nonce_w[0]; k[1] = nonce_w[1];
        for (int j = 0; j < 4; j++) k[4 + j] = key_w[j];
        k[12] = 64'd64; k[13] = 64'(ROUNDS); k[14] = 64'(TAG_BITS); k[15] = tagnum;
        return scramble(k);
    endfunction

    function automatic blk_t advance(blk_t k);
        blk_t r;
        for (int j = 0; j < 15; j++) r[j] = k[j + 1];
        r[15] = rotr(k[0], 9) ^ (k[9] >> 7);
        return r;
    endfunction

    function automatic blk_t shift_words(blk_t k, int by);
        blk_t r;
        for (int j = 0; j < 16; j++) r[j] = k[(j + by) % 16];
        return r;
    endfunction

    function automatic blk_t padded(blk_t src, int len);
        blk_t d;
        d = '0;
        for (int j = 0; j < (len + 7) / 8 && j < 16; j++) d[j] = src[j];
        d[(len / 8) % 16] = d[(len / 8) % 16] | (64'h1 << (8 * (len % 8)));
        d[15] = d[15] | (64'h80 << 56);
        return d;
    endfunction

    function automatic void emit(logic [1:0] kind, word_t data, int nb, logic ok);
        out_word_t o;
        o.kind = kind; o.data = data; o.nb = 4'(nb); o.last = 1'b0; o.ok = ok;
        expected_q.push_back(o);
    endfunction

    function automatic void absorb(blk_t blk);
        blk_t b;
        b = scramble(hdr_mask ^ blk);
        hdr_sum = hdr_sum ^ hdr_mask ^ b;
        hdr_mask = advance(hdr_mask);
    endfunction

    function automatic void absorb_tail(int len);
        blk_t p;
        p = padded(blk_buf, len);
        hdr_mask = shift_words(hdr_mask, 4);
        absorb(p);
    endfunction

    function automatic void crypt_block();
        blk_t  b;
        word_t o;
        b = pay_mask ^ blk_buf;
        b = dir_dec ? unscramble(b) : scramble(b);
        for (int j = 0; j < 16; j++) begin
            o = pay_mask[j] ^ b[j];
            emit(KIND_PAY, o, 8, 1'b0);
            pay_sum[j] = pay_sum[j] ^ (dir_dec ? o : blk_buf[j]);
        end
        pay_mask = advance(pay_mask);
    endfunction

    // partial final block: keystream from the rotated mask, then pad into sum
    function automatic void crypt_tail(int len);
        blk_t b, o;
        int   words, nbj;
        words = (len + 7) / 8;
        pay_mask = shift_words(pay_mask, 12);
        b = scramble(pay_mask);
        o = '0;
        for (int j = 0; j < words; j++) begin
            nbj = (j + 1 == words) ? len - 8 * j : 8;
            o[j] = (b[j] ^ pay_mask[j] ^ blk_buf[j]) & low_bytes(nbj);
            emit(KIND_PAY, o[j], nbj, 1'b0);
        end
        pay_sum = pay_sum ^ padded(dir_dec ? o : blk_buf, len);
    endfunction

    function automatic void engine_step(in_word_t it);
        int    n, len, first;
        logic  ends;
        word_t w;
        n = it.nb;
        if (n == 0 || n > 8) n = 8;
        w = it.data & low_bytes(n);
        ends = it.last || n < 8;
        first = expected_q.size();
        if (it.cmd == CMD_START) begin
            hdr_mask = seed_mask(64'd0);
            pay_mask = seed_mask(64'd1);
            hdr_sum = '0; pay_sum = '0;
            fill = 0; sess = ST_HEAD; tag_pos = 0; tag_good = 1'b1;
        end else if (it.cmd == CMD_HEADER && sess == ST_HEAD) begin
            blk_buf[fill] = w;
            len = fill * 8 + n;
            if (len == 128) begin
                absorb(blk_buf); fill = 0;
            end else if (ends) begin
                absorb_tail(len); fill = 0;
            end else begin
                fill++;
            end
            if (ends) sess = ST_PAY;
        end else if (it.cmd == CMD_PAY && (sess == ST_HEAD || sess == ST_PAY)) begin
            if (sess == ST_HEAD) begin
                if (fill > 0) absorb_tail(fill * 8);
                fill = 0; sess = ST_PAY;
            end
            blk_buf[fill] = w;
            len = fill * 8 + n;
            if (len == 128) begin
                crypt_block(); fill = 0;
            end else if (ends) begin
                crypt_tail(len); fill = 0;
            end else begin
                fill++;
            end
            if (ends) sess = ST_CLOSED;
        end else if (it.cmd == CMD_FINISH && (sess == ST_HEAD || sess == ST_CLOSED ||
                                              (sess == ST_PAY && fill == 0))) begin
            if (sess == ST_HEAD && fill > 0) absorb_tail(fill * 8);
            fill = 0;
            hdr_mask = shift_words(hdr_mask, 8);
            pay_sum = scramble(pay_sum ^ hdr_mask);
            hdr_sum = hdr_sum ^ pay_sum ^ hdr_mask;
            if (!dir_dec) begin
                for (int j = 0; j < TAG_WORDS; j++) emit(KIND_TAG, hdr_sum[j], 8, 1'b0);
                sess = ST_IDLE;
            end else begin
                sess = ST_VERIFY; tag_pos = 0; tag_good = 1'b1;
            end
        end else if (it.cmd == CMD_TAG && sess == ST_VERIFY) begin
            if (it.data != hdr_sum[tag_pos]) tag_good = 1'b0;
            if (tag_pos == TAG_WORDS - 1) begin
                emit(KIND_VERDICT, '0, 8, tag_good);
                sess = ST_IDLE; tag_pos = 0;
            end else begin
                tag_pos++;
            end
        end
        if (expected_q.size() > first) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    // sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        logic nxt_valid;
        nxt_valid = s_tvalid;
        if (aresetn && (!s_tvalid || s_tready)) begin
            if (s_tvalid) engine_step(cur_word);
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_q.size() > 0) begin
                cur_word = pending_q.pop_front();
                s_tdata <= {4'd0, cur_word.nb, cur_word.data};
                s_tuser <= cur_word.cmd;
                s_tlast <= cur_word.last;
                nxt_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        s_tvalid <= nxt_valid;
    end

    // receiver: stall mode drawn anew at random each time the mode counter wraps
    int stall_mode = 0;
    int mode_cnt = 0;

    always @(posedge aclk) begin
        if (mode_cnt == 199) begin
            mode_cnt <= 0;
            stall_mode <= $urandom_range(0, 3);
        end else begin
            mode_cnt <= mode_cnt + 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic report(string what, logic [63:0] want, logic [63:0] got);
        $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
        errors++;
    endtask

    always @(posedge aclk) begin
        out_word_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report("unexpected word", '0, m_tdata[63:0]);
            end else begin
                e = expected_q.pop_front();
                if (m_tuser != e.kind) report("kind", e.kind, m_tuser);
                if (m_tdata[63:0] != e.data) report("data", e.data, m_tdata[63:0]);
                if (m_tdata[67:64] != e.nb) report("bytes", e.nb, m_tdata[67:64]);
                if (m_tdata[68] != e.ok) report("auth_ok", e.ok, m_tdata[68]);
                if (m_tlast != e.last) report("last", e.last, m_tlast);
            end
        end
    end

    function automatic word_t rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void queue_word(logic [2:0] cmd, word_t data, int nb, logic last);
        in_word_t it;
        it.cmd = cmd; it.data = data; it.nb = 4'(nb); it.last = last;
        pending_q.push_back(it);
    endfunction

    task automatic wait_sent();
        do @(posedge aclk); while (pending_q.size() != 0 || s_tvalid);
    endtask

    // let the engine finish any work that produces no result
    task automatic wait_quiet();
        wait_sent();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, word_t val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_KEY0: key_w[0] = val;
            CFG_KEY1: key_w[1] = val;
            CFG_KEY2: key_w[2] = val;
            CFG_KEY3: key_w[3] = val;
            CFG_NONCE0: nonce_w[0] = val;
            CFG_NONCE1: nonce_w[1] = val;
            CFG_DIR: dir_dec = val[0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_tags(logic corrupt);
        int bad;
        wait_sent();
        bad = corrupt ? $urandom_range(0, 3) : 4;
        for (int j = 0; j < TAG_WORDS; j++) begin
            queue_word(CMD_TAG, (j == bad) ? hdr_sum[j] ^ (64'd1 << $urandom_range(0, 63))
                                           : hdr_sum[j], $urandom_range(0, 15), j == 3);
        end
    endtask

    function automatic int pick_nb(logic is_last);
        int r;
        r = $urandom_range(0, 9);
        if (is_last && r < 4) return $urandom_range(1, 7);
        if (r == 9) return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(9, 15);
        return 8;
    endfunction

    task automatic section(logic [2:0] cmd, int count);
        logic lst;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                queue_word(3'($urandom_range(1, 7)), rand64(), $urandom_range(0, 15),
                           $urandom_range(0, 1));
            end
            lst = (i == count - 1) && ($urandom_range(0, 5) != 0);
            queue_word(cmd, rand64(), pick_nb(i == count - 1), lst);
        end
    endtask

    function automatic int pick_len(int deep, int brief);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, deep) : $urandom_range(0, brief);
    endfunction

    initial begin
        int sent;
        word_t ones;
        ones = '1;
        key_w = '{default: '0};
        nonce_w = '{default: '0};
        dir_dec = 1'b0;
        blk_buf = '0; hdr_mask = '0; pay_mask = '0; hdr_sum = '0; pay_sum = '0;
        fill = 0; sess = ST_IDLE; tag_pos = 0; tag_good = 1'b1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < 6; r++) write_reg(3'(r), ones);
        write_reg(CFG_DIR, 64'd0);
        end_writes();

        // directed: wrong-phase words, odd byte counts, early closes
        queue_word(3'd7, ones, 8, 1'b1);
        queue_word(CMD_FINISH, '0, 8, 1'b0);
        queue_word(CMD_TAG, ones, 8, 1'b1);
        queue_word(CMD_START, ones, 0, 1'b1);
        queue_word(CMD_HEADER, ones, 8, 1'b0);
        queue_word(CMD_HEADER, ones, 3, 1'b0);
        queue_word(CMD_HEADER, ones, 8, 1'b1);
        queue_word(CMD_PAY, ones, 0, 1'b0);
        queue_word(CMD_FINISH, '0, 8, 1'b0);
        queue_word(CMD_PAY, ones, 1, 1'b1);
        queue_word(CMD_PAY, '0, 8, 1'b1);
        queue_word(CMD_FINISH, '0, 8, 1'b0);
        queue_word(CMD_START, '0, 8, 1'b0);
        queue_word(CMD_HEADER, '0, 9, 1'b0);
        queue_word(CMD_FINISH, '0, 8, 1'b0);
        queue_word(CMD_START, '0, 15, 1'b0);
        queue_word(CMD_FINISH, '0, 8, 1'b0);
        wait_quiet();
        write_reg(CFG_DIR, 64'd1);
        end_writes();
        queue_word(CMD_START, '0, 8, 1'b0);
        queue_word(CMD_HEADER, ones, 8, 1'b0);
        queue_word(CMD_PAY, ones, 12, 1'b1);
        queue_word(CMD_FINISH, '0, 8, 1'b0);
        send_tags(1'b0);

        // random sessions under a sequence of key, nonce and direction settings
        for (int ph = 0; ph < 6; ph++) begin
            wait_quiet();
            for (int r = 0; r < 6; r++) begin
                write_reg(3'(r), (ph == 0) ? 64'd0 : (ph == 1) ? ones : rand64());
            end
            write_reg(CFG_DIR, 64'(ph % 2 == 1));
            end_writes();
            // two sessions per setting, each of random length
            sent = 0;
            while (sent < 2) begin
                queue_word(CMD_START, rand64(), $urandom_range(0, 15), $urandom_range(0, 1));
                section(CMD_HEADER, pick_len(20, 4));
                section(CMD_PAY, pick_len(40, 6));
                queue_word(CMD_FINISH, rand64(), $urandom_range(0, 15), $urandom_range(0, 1));
                if (dir_dec) send_tags($urandom_range(0, 2) == 0);
                sent++;
                wait_sent();
            end
        end

        wait_quiet();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(20 * 3000000);
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/oae_pkg.sv
design/oae_datapath.sv
design/oae_ctrl.sv
design/opp_aead_engine.sv
test/tb_opp_aead_engine.sv
